// ----- rtl/core/ipv6_to_ipv4_header_translate_defines.svh -----
// ----------------------------------------------------------------------------
// IPv6 to IPv4 header translator - assertion macros
// Shared immediate-style wrappers around concurrent assertions on clk/rst_n.
// ----------------------------------------------------------------------------
`ifndef IPV6_TO_IPV4_HEADER_TRANSLATE_DEFINES_SVH
`define IPV6_TO_IPV4_HEADER_TRANSLATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define V6V4_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define V6V4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/v6v4_pkg.sv -----
// ----------------------------------------------------------------------------
// v6v4_pkg
// Types and constants shared by the IPv6 to IPv4 header translator.
// ----------------------------------------------------------------------------
package v6v4_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCAL_V6_HIGH = 3'd0,
    REG_LOCAL_V6_LOW  = 3'd1,
    REG_PREFIX_HIGH   = 3'd2,
    REG_PREFIX_MID    = 3'd3,
    REG_LOCAL_V4      = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_DROP  = 2'd1,
    VERDICT_XLATE = 2'd2
  } verdict_t;

  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
  localparam logic [7:0] PROTO_ICMP   = 8'd1;

  // ICMPv6 types
  localparam logic [7:0] ICMP6_DST_UNREACH  = 8'd1;
  localparam logic [7:0] ICMP6_PKT_TOO_BIG  = 8'd2;
  localparam logic [7:0] ICMP6_TIME_EXCEED  = 8'd3;
  localparam logic [7:0] ICMP6_PARAM_PROB   = 8'd4;
  localparam logic [7:0] ICMP6_ECHO_REQUEST = 8'd128;
  localparam logic [7:0] ICMP6_ECHO_REPLY   = 8'd129;

  // ICMPv4 types
  localparam logic [7:0] ICMP4_ECHO_REPLY   = 8'd0;
  localparam logic [7:0] ICMP4_DST_UNREACH  = 8'd3;
  localparam logic [7:0] ICMP4_ECHO_REQUEST = 8'd8;
  localparam logic [7:0] ICMP4_TIME_EXCEED  = 8'd11;
  localparam logic [7:0] ICMP4_PARAM_PROB   = 8'd12;

  localparam logic [15:0] V4_HDR_LEN   = 16'd20;
  localparam logic [15:0] V4_VER_IHL   = 16'h4500;
  localparam logic [15:0] V4_FLAGS_DF  = 16'h4000;

  typedef struct packed {
    logic [63:0] local_v6_high;
    logic [63:0] local_v6_low;
    logic [63:0] prefix_high;
    logic [31:0] prefix_mid;
    logic [31:0] local_v4;
  } cfg_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [31:0] icmp_rest;
  } icmp_map_t;

endpackage

// ----- rtl/core/v6v4_cfg.sv -----
// ----------------------------------------------------------------------------
// v6v4_cfg
// Configuration register bank; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module v6v4_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [v6v4_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [63:0]                     wr_data,
  output v6v4_pkg::cfg_t                  cfg
);

  v6v4_pkg::cfg_t cfg_r;
  v6v4_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (v6v4_pkg::cfg_idx_t'(wr_index))
        v6v4_pkg::REG_LOCAL_V6_HIGH: cfg_nxt.local_v6_high = wr_data;
        v6v4_pkg::REG_LOCAL_V6_LOW:  cfg_nxt.local_v6_low  = wr_data;
        v6v4_pkg::REG_PREFIX_HIGH:   cfg_nxt.prefix_high   = wr_data;
        v6v4_pkg::REG_PREFIX_MID:    cfg_nxt.prefix_mid    = wr_data[31:0];
        v6v4_pkg::REG_LOCAL_V4:      cfg_nxt.local_v4      = wr_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/v6v4_icmp_map.sv -----
// ----------------------------------------------------------------------------
// v6v4_icmp_map
// ICMPv6 to ICMPv4 type, code and rest-word remapping.
// ----------------------------------------------------------------------------
module v6v4_icmp_map (
  input  logic [7:0]            icmp_type,
  input  logic [7:0]            icmp_code,
  input  logic [31:0]           icmp_rest,
  output v6v4_pkg::icmp_map_t   map
);

  logic [31:0] mtu;

  // MTU shrinks by the header size difference
  assign mtu = icmp_rest - 32'd20;

  always_comb begin
    map.ok        = 1'b1;
    map.icmp_type = v6v4_pkg::ICMP4_ECHO_REPLY;
    map.icmp_code = icmp_code;
    map.icmp_rest = icmp_rest;
    unique case (icmp_type)
      v6v4_pkg::ICMP6_ECHO_REQUEST: map.icmp_type = v6v4_pkg::ICMP4_ECHO_REQUEST;
      v6v4_pkg::ICMP6_ECHO_REPLY:   map.icmp_type = v6v4_pkg::ICMP4_ECHO_REPLY;
      v6v4_pkg::ICMP6_DST_UNREACH: begin
        map.icmp_type = v6v4_pkg::ICMP4_DST_UNREACH;
        unique case (icmp_code)
          8'd0, 8'd2, 8'd3: map.icmp_code = 8'd1;
          8'd1:             map.icmp_code = 8'd10;
          8'd4:             map.icmp_code = 8'd3;
          default:          map.ok = 1'b0;
        endcase
      end
      v6v4_pkg::ICMP6_PKT_TOO_BIG: begin
        map.icmp_type = v6v4_pkg::ICMP4_DST_UNREACH;
        map.icmp_code = 8'd4;
        map.icmp_rest = {icmp_rest[31:16], mtu[15:0]};
        map.ok        = (mtu[31:16] == 16'd0);
      end
      v6v4_pkg::ICMP6_TIME_EXCEED: map.icmp_type = v6v4_pkg::ICMP4_TIME_EXCEED;
      v6v4_pkg::ICMP6_PARAM_PROB: begin
        priority if (icmp_code == 8'd0) begin
          map.icmp_type = v6v4_pkg::ICMP4_PARAM_PROB;
          map.icmp_code = 8'd0;
          map.icmp_rest = '0;
          if (icmp_rest[31:6] != 26'd0) begin
            map.ok = 1'b0;
          end else begin
            // remap the pointer into the IPv4 header layout
            unique case (icmp_rest[5:0])
              6'd0:            map.icmp_rest[31:24] = 8'd0;
              6'd1:            map.icmp_rest[31:24] = 8'd1;
              6'd4, 6'd5:      map.icmp_rest[31:24] = 8'd2;
              6'd6:            map.icmp_rest[31:24] = 8'd9;
              6'd7:            map.icmp_rest[31:24] = 8'd8;
              6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
              6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23:
                               map.icmp_rest[31:24] = 8'd12;
              6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
              6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39:
                               map.icmp_rest[31:24] = 8'd16;
              default:         map.ok = 1'b0;
            endcase
          end
        end else if (icmp_code == 8'd1) begin
          map.icmp_type = v6v4_pkg::ICMP4_DST_UNREACH;
          map.icmp_code = 8'd2;
        end else begin
          map.ok = 1'b0;
        end
      end
      default: map.ok = 1'b0;
    endcase
  end

endmodule

// ----- rtl/core/v6v4_csum.sv -----
// ----------------------------------------------------------------------------
// v6v4_csum
// IPv4 header checksum with id zero and DF set.
// ----------------------------------------------------------------------------
module v6v4_csum (
  input  logic [7:0]  tos,
  input  logic [15:0] total_length,
  input  logic [7:0]  ttl,
  input  logic [7:0]  protocol,
  input  logic [31:0] src,
  input  logic [31:0] dst,
  output logic [15:0] checksum
);

  logic [18:0] sum;
  logic [16:0] fold1;
  logic [16:0] fold2;

  // eight 16-bit words, at most 19 bits wide
  assign sum = {3'd0, v6v4_pkg::V4_VER_IHL | {8'd0, tos}}
             + {3'd0, total_length}
             + {3'd0, v6v4_pkg::V4_FLAGS_DF}
             + {3'd0, ttl, protocol}
             + {3'd0, src[31:16]} + {3'd0, src[15:0]}
             + {3'd0, dst[31:16]} + {3'd0, dst[15:0]};

  assign fold1 = {14'd0, sum[18:16]} + {1'b0, sum[15:0]};
  assign fold2 = fold1 + {16'd0, fold1[16]};
  assign checksum = ~fold2[15:0];

endmodule

// ----- rtl/core/ipv6_to_ipv4_header_translate.sv -----
// A request goes from the input register to the result register, which drives out_valid.
// Throughput: one request per cycle while out_ready stays high.
// Input and result registers part the two sides, with one combinational pass between them.
// Reset (synchronous, rst_n low) empties both stages and clears all configuration to zero.
// cfg_ready is always high; configuration is applied at the edge it is accepted.
// ----------------------------------------------------------------------------
// ipv6_to_ipv4_header_translate
// Stateless IPv6 to IPv4 header translation: classify, remap ICMP, checksum.
// ----------------------------------------------------------------------------
`include "ipv6_to_ipv4_header_translate_defines.svh"

module ipv6_to_ipv4_header_translate (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration port
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [v6v4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                     cfg_data,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [63:0]                     in_dst_addr_high,
  input  logic [63:0]                     in_dst_addr_low,
  input  logic [63:0]                     in_src_addr_high,
  input  logic [63:0]                     in_src_addr_low,
  input  logic [7:0]                      in_next_header,
  input  logic [7:0]                      in_hop_count,
  input  logic [7:0]                      in_traffic_class,
  input  logic [15:0]                     in_payload_length,
  input  logic                            in_ext_headers_present,
  input  logic [7:0]                      in_icmp_type_in,
  input  logic [7:0]                      in_icmp_code_in,
  input  logic [31:0]                     in_icmp_rest_in,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_verdict,
  output logic [31:0]                     out_v4_source,
  output logic [7:0]                      out_v4_protocol,
  output logic [7:0]                      out_v4_ttl,
  output logic [7:0]                      out_v4_tos,
  output logic [15:0]                     out_v4_total_length,
  output logic [15:0]                     out_v4_checksum,
  output logic [7:0]                      out_icmp_type_out,
  output logic [7:0]                      out_icmp_code_out,
  output logic [31:0]                     out_icmp_rest_out
);

  // Captured request payload
  typedef struct packed {
    logic [63:0] dst_high;
    logic [63:0] dst_low;
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [7:0]  next_header;
    logic [7:0]  hop_count;
    logic [7:0]  traffic_class;
    logic [15:0] payload_length;
    logic        ext_present;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [31:0] icmp_rest;
  } req_t;

  // Result register contents
  typedef struct packed {
    v6v4_pkg::verdict_t verdict;
    logic [31:0]        v4_source;
    logic [7:0]         v4_protocol;
    logic [7:0]         v4_ttl;
    logic [7:0]         v4_tos;
    logic [15:0]        v4_total_length;
    logic [15:0]        v4_checksum;
    logic [7:0]         icmp_type;
    logic [7:0]         icmp_code;
    logic [31:0]        icmp_rest;
  } res_t;

  v6v4_pkg::cfg_t      cfg;
  v6v4_pkg::icmp_map_t icmp_map;

  logic  req_valid_r, req_valid_nxt;
  logic  out_valid_r, out_valid_nxt;
  req_t  req_r;
  res_t  res_r, res_nxt;

  logic        in_accept;
  logic        res_load;
  logic        addr_hit;
  logic        dst_special;
  logic        is_icmp;
  logic [31:0] dst_v4;
  logic [7:0]  v4_proto;
  logic [15:0] v4_tlen;
  logic [15:0] v4_csum;

  logic        res_not_xlate;
  logic        res_fields_zero;
  logic        res_plain_xlate;
  logic        res_icmp_zero;

  // --------------------------------------------------------------------------
  // Configuration bank: always ready, writes land at the accepting edge
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  v6v4_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // --------------------------------------------------------------------------
  // Handshake: the input register refills whenever its contents advance
  // --------------------------------------------------------------------------
  assign res_load  = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !req_valid_r || res_load;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_accept) begin
      req_valid_nxt = 1'b1;
    end else if (res_load) begin
      req_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the request until it moves on to the result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r.dst_high       <= in_dst_addr_high;
      req_r.dst_low        <= in_dst_addr_low;
      req_r.src_high       <= in_src_addr_high;
      req_r.src_low        <= in_src_addr_low;
      req_r.next_header    <= in_next_header;
      req_r.hop_count      <= in_hop_count;
      req_r.traffic_class  <= in_traffic_class;
      req_r.payload_length <= in_payload_length;
      req_r.ext_present    <= in_ext_headers_present;
      req_r.icmp_type      <= in_icmp_type_in;
      req_r.icmp_code      <= in_icmp_code_in;
      req_r.icmp_rest      <= in_icmp_rest_in;
    end
  end

  // --------------------------------------------------------------------------
  // Classification: translate only traffic to the local address from the prefix
  // --------------------------------------------------------------------------
  assign addr_hit = (req_r.dst_high == cfg.local_v6_high) &&
                    (req_r.dst_low  == cfg.local_v6_low)  &&
                    (req_r.src_high == cfg.prefix_high)   &&
                    (req_r.src_low[63:32] == cfg.prefix_mid);

  // Embedded IPv4 destination: drop zero, loopback and multicast
  assign dst_v4      = req_r.dst_low[31:0];
  assign dst_special = (dst_v4 == 32'd0) ||
                       (dst_v4[31:24] == 8'h7F) ||
                       (dst_v4[31:28] == 4'hE);

  assign is_icmp  = (req_r.next_header == v6v4_pkg::PROTO_ICMPV6);
  assign v4_proto = is_icmp ? v6v4_pkg::PROTO_ICMP : req_r.next_header;
  // total length wraps modulo 2^16
  assign v4_tlen  = req_r.payload_length + v6v4_pkg::V4_HDR_LEN;

  v6v4_icmp_map u_icmp_map (
    .icmp_type (req_r.icmp_type),
    .icmp_code (req_r.icmp_code),
    .icmp_rest (req_r.icmp_rest),
    .map       (icmp_map)
  );

  v6v4_csum u_csum (
    .tos          (req_r.traffic_class),
    .total_length (v4_tlen),
    .ttl          (req_r.hop_count),
    .protocol     (v4_proto),
    .src          (req_r.src_low[31:0]),
    .dst          (cfg.local_v4),
    .checksum     (v4_csum)
  );

  // Build the result; pass and drop carry zeros in every field but the verdict
  always_comb begin
    res_nxt = '0;
    priority if (!addr_hit) begin
      res_nxt.verdict = v6v4_pkg::VERDICT_PASS;
    end else if (req_r.ext_present || dst_special || (is_icmp && !icmp_map.ok)) begin
      res_nxt.verdict = v6v4_pkg::VERDICT_DROP;
    end else begin
      res_nxt.verdict         = v6v4_pkg::VERDICT_XLATE;
      res_nxt.v4_source       = req_r.src_low[31:0];
      res_nxt.v4_protocol     = v4_proto;
      res_nxt.v4_ttl          = req_r.hop_count;
      res_nxt.v4_tos          = req_r.traffic_class;
      res_nxt.v4_total_length = v4_tlen;
      res_nxt.v4_checksum     = v4_csum;
      if (is_icmp) begin
        res_nxt.icmp_type = icmp_map.icmp_type;
        res_nxt.icmp_code = icmp_map.icmp_code;
        res_nxt.icmp_rest = icmp_map.icmp_rest;
      end
    end
  end

  // Advance into the result register only when it is free or being emptied
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_verdict         = res_r.verdict;
  assign out_v4_source       = res_r.v4_source;
  assign out_v4_protocol     = res_r.v4_protocol;
  assign out_v4_ttl          = res_r.v4_ttl;
  assign out_v4_tos          = res_r.v4_tos;
  assign out_v4_total_length = res_r.v4_total_length;
  assign out_v4_checksum     = res_r.v4_checksum;
  assign out_icmp_type_out   = res_r.icmp_type;
  assign out_icmp_code_out   = res_r.icmp_code;
  assign out_icmp_rest_out   = res_r.icmp_rest;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  assign res_not_xlate   = out_valid && (out_verdict != v6v4_pkg::VERDICT_XLATE);
  assign res_fields_zero = (out_v4_source == 32'd0) && (out_v4_checksum == 16'd0) &&
                           (out_icmp_rest_out == 32'd0);
  assign res_plain_xlate = out_valid && (out_verdict == v6v4_pkg::VERDICT_XLATE) &&
                           (out_v4_protocol != v6v4_pkg::PROTO_ICMP);
  assign res_icmp_zero   = (out_icmp_type_out == 8'd0) && (out_icmp_code_out == 8'd0) &&
                           (out_icmp_rest_out == 32'd0);

  `V6V4_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, req_valid_r, "accepted request lost")
  `V6V4_ASSERT_NEXT(a_load_shows, res_load, out_valid, "loaded result not presented")
  `V6V4_ASSERT_SAME(a_untranslated_zero, res_not_xlate, res_fields_zero, "pass or drop has data")
  `V6V4_ASSERT_SAME(a_non_icmp_zero, res_plain_xlate, res_icmp_zero, "ICMP fields on non-ICMP")

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb - IPv6 to IPv4 header translator testbench
// Drives parsed IPv6 headers through the request channel and compares every
// result, field by field, with a local model of the translation. Register
// settings change between phases, only once the block has drained.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import v6v4_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 10;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_REQUESTS = 250;
  localparam int GAP_MAX        = 6;
  localparam int HOLD_AT_FIRST  = 300;
  localparam int HOLD_AT_SECOND = 1200;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  // register index the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // ICMPv6 type with no IPv4 counterpart
  localparam logic [7:0] ICMP6_NEIGH_SOLICIT = 8'd135;
  // codes that are simply carried through
  localparam logic [7:0] CODE_ZERO     = 8'h00;
  localparam logic [7:0] CODE_ALL_ONES = 8'hFF;
  localparam logic [7:0] TE6_REASSEMBLY = 8'd1;

  // ICMPv6 destination unreachable codes
  localparam logic [7:0] U6_NO_ROUTE     = 8'd0;
  localparam logic [7:0] U6_ADMIN_PROHIB = 8'd1;
  localparam logic [7:0] U6_BEYOND_SCOPE = 8'd2;
  localparam logic [7:0] U6_ADDR_UNREACH = 8'd3;
  localparam logic [7:0] U6_PORT_UNREACH = 8'd4;
  localparam logic [7:0] U6_SRC_POLICY   = 8'd5;
  // ICMPv4 destination unreachable codes
  localparam logic [7:0] U4_HOST_UNREACH  = 8'd1;
  localparam logic [7:0] U4_PROTO_UNREACH = 8'd2;
  localparam logic [7:0] U4_PORT_UNREACH  = 8'd3;
  localparam logic [7:0] U4_FRAG_NEEDED   = 8'd4;
  localparam logic [7:0] U4_HOST_ADMIN    = 8'd10;
  // parameter problem codes
  localparam logic [7:0] PP6_HDR_FIELD = 8'd0;
  localparam logic [7:0] PP6_UNREC_NH  = 8'd1;
  localparam logic [7:0] PP6_UNREC_OPT = 8'd2;
  localparam logic [7:0] PP4_POINTER   = 8'd0;

  typedef struct packed {
    logic [63:0] dst_high;
    logic [63:0] dst_low;
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [7:0]  next_header;
    logic [7:0]  hop_count;
    logic [7:0]  traffic_class;
    logic [15:0] payload_length;
    logic        ext;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [31:0] icmp_rest;
  } v6_hdr_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] source;
    logic [7:0]  protocol;
    logic [7:0]  ttl;
    logic [7:0]  tos;
    logic [15:0] total_length;
    logic [15:0] checksum;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [31:0] icmp_rest;
  } v4_hdr_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data  = '0;

  logic        in_valid               = 1'b0;
  logic        in_ready;
  logic [63:0] in_dst_addr_high       = '0;
  logic [63:0] in_dst_addr_low        = '0;
  logic [63:0] in_src_addr_high       = '0;
  logic [63:0] in_src_addr_low        = '0;
  logic [7:0]  in_next_header         = '0;
  logic [7:0]  in_hop_count           = '0;
  logic [7:0]  in_traffic_class       = '0;
  logic [15:0] in_payload_length      = '0;
  logic        in_ext_headers_present = 1'b0;
  logic [7:0]  in_icmp_type_in        = '0;
  logic [7:0]  in_icmp_code_in        = '0;
  logic [31:0] in_icmp_rest_in        = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_verdict;
  logic [31:0] out_v4_source;
  logic [7:0]  out_v4_protocol;
  logic [7:0]  out_v4_ttl;
  logic [7:0]  out_v4_tos;
  logic [15:0] out_v4_total_length;
  logic [15:0] out_v4_checksum;
  logic [7:0]  out_icmp_type_out;
  logic [7:0]  out_icmp_code_out;
  logic [31:0] out_icmp_rest_out;

  // headers waiting to be offered, and translations waiting to come out
  v6_hdr_t hdr_queue[$];
  v4_hdr_t v4_due[$];

  cfg_t    shadow_cfg = '0;
  v6_hdr_t cur_hdr;

  int send_gap_max = GAP_MAX;
  int recv_gap_max = GAP_MAX;
  int send_gap     = 0;
  int recv_gap     = 0;
  int hold_left    = 0;
  int stall_cycles = 0;

  int mismatches    = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int n_xlate       = 0;
  int n_drop        = 0;
  int n_pass        = 0;

  ipv6_to_ipv4_header_translate i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_dst_addr_high       (in_dst_addr_high),
    .in_dst_addr_low        (in_dst_addr_low),
    .in_src_addr_high       (in_src_addr_high),
    .in_src_addr_low        (in_src_addr_low),
    .in_next_header         (in_next_header),
    .in_hop_count           (in_hop_count),
    .in_traffic_class       (in_traffic_class),
    .in_payload_length      (in_payload_length),
    .in_ext_headers_present (in_ext_headers_present),
    .in_icmp_type_in        (in_icmp_type_in),
    .in_icmp_code_in        (in_icmp_code_in),
    .in_icmp_rest_in        (in_icmp_rest_in),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_verdict            (out_verdict),
    .out_v4_source          (out_v4_source),
    .out_v4_protocol        (out_v4_protocol),
    .out_v4_ttl             (out_v4_ttl),
    .out_v4_tos             (out_v4_tos),
    .out_v4_total_length    (out_v4_total_length),
    .out_v4_checksum        (out_v4_checksum),
    .out_icmp_type_out      (out_icmp_type_out),
    .out_icmp_code_out      (out_icmp_code_out),
    .out_icmp_rest_out      (out_icmp_rest_out)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ------------------------------------------------------------------------
  // Translation model
  // ------------------------------------------------------------------------

  // One's complement sum over the ten header words; id is zero, DF set.
  function automatic logic [15:0] v4_header_checksum(logic [7:0] tos, logic [15:0] tlen,
                                                     logic [7:0] ttl, logic [7:0] proto,
                                                     logic [31:0] src, logic [31:0] dst);
    logic [31:0] sum;
    sum = {16'h0, V4_VER_IHL | {8'h00, tos}};
    sum += {16'h0, tlen};
    sum += {16'h0, V4_FLAGS_DF};
    sum += {16'h0, ttl, proto};
    sum += {16'h0, src[31:16]};
    sum += {16'h0, src[15:0]};
    sum += {16'h0, dst[31:16]};
    sum += {16'h0, dst[15:0]};
    sum = (sum >> 16) + (sum & 32'h0000_ffff);
    sum += sum >> 16;
    return ~sum[15:0];
  endfunction

  function automatic v4_hdr_t translate_header(v6_hdr_t h, cfg_t c);
    v4_hdr_t     r;
    logic [31:0] dst4;
    logic [31:0] mtu;
    logic [31:0] rest;
    logic [7:0]  proto;
    logic [7:0]  ty;
    logic [7:0]  co;
    logic        ok;
    r = '0;
    r.verdict = VERDICT_PASS;
    // not ours: pass untouched unless addressed to us from the mapped prefix
    if (h.dst_high != c.local_v6_high || h.dst_low != c.local_v6_low ||
        h.src_high != c.prefix_high || h.src_low[63:32] != c.prefix_mid)
      return r;
    r.verdict = VERDICT_DROP;
    // drop on extension headers and on zero, loopback or multicast destinations
    dst4 = h.dst_low[31:0];
    if (h.ext || dst4 == 32'd0 || dst4[31:24] == 8'h7F || dst4[31:28] == 4'hE)
      return r;
    proto = h.next_header;
    ty    = '0;
    co    = '0;
    rest  = '0;
    ok    = 1'b1;
    if (h.next_header == PROTO_ICMPV6) begin
      proto = PROTO_ICMP;
      co    = h.icmp_code;
      rest  = h.icmp_rest;
      case (h.icmp_type)
        ICMP6_ECHO_REQUEST: ty = ICMP4_ECHO_REQUEST;
        ICMP6_ECHO_REPLY:   ty = ICMP4_ECHO_REPLY;
        ICMP6_DST_UNREACH: begin
          ty = ICMP4_DST_UNREACH;
          case (h.icmp_code)
            U6_NO_ROUTE, U6_BEYOND_SCOPE, U6_ADDR_UNREACH: co = U4_HOST_UNREACH;
            U6_ADMIN_PROHIB: co = U4_HOST_ADMIN;
            U6_PORT_UNREACH: co = U4_PORT_UNREACH;
            default: ok = 1'b0;
          endcase
        end
        ICMP6_PKT_TOO_BIG: begin
          // the subtraction wraps, so a tiny MTU lands far above 16 bits
          mtu  = h.icmp_rest - 32'd20;
          ty   = ICMP4_DST_UNREACH;
          co   = U4_FRAG_NEEDED;
          ok   = (mtu <= 32'h0000_ffff);
          rest = {h.icmp_rest[31:16], mtu[15:0]};
        end
        ICMP6_TIME_EXCEED: ty = ICMP4_TIME_EXCEED;
        ICMP6_PARAM_PROB: begin
          if (h.icmp_code == PP6_HDR_FIELD) begin
            ty   = ICMP4_PARAM_PROB;
            co   = PP4_POINTER;
            rest = '0;
            if (h.icmp_rest <= 32'd1) rest[31:24] = h.icmp_rest[7:0];
            else if (h.icmp_rest == 32'd4 || h.icmp_rest == 32'd5) rest[31:24] = 8'd2;
            else if (h.icmp_rest == 32'd6) rest[31:24] = 8'd9;
            else if (h.icmp_rest == 32'd7) rest[31:24] = 8'd8;
            else if (h.icmp_rest >= 32'd8 && h.icmp_rest <= 32'd23) rest[31:24] = 8'd12;
            else if (h.icmp_rest >= 32'd24 && h.icmp_rest <= 32'd39) rest[31:24] = 8'd16;
            else ok = 1'b0;
          end else if (h.icmp_code == PP6_UNREC_NH) begin
            ty = ICMP4_DST_UNREACH;
            co = U4_PROTO_UNREACH;
          end else begin
            ok = 1'b0;
          end
        end
        default: ok = 1'b0;
      endcase
    end
    if (!ok)
      return r;
    r.verdict      = VERDICT_XLATE;
    r.source       = h.src_low[31:0];
    r.protocol     = proto;
    r.ttl          = h.hop_count;
    r.tos          = h.traffic_class;
    r.total_length = h.payload_length + V4_HDR_LEN;
    r.checksum     = v4_header_checksum(h.traffic_class, r.total_length, h.hop_count,
                                        proto, r.source, c.local_v4);
    r.icmp_type    = ty;
    r.icmp_code    = co;
    r.icmp_rest    = rest;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Header generation
  // ------------------------------------------------------------------------

  // A header addressed to us from the prefix, with random content.
  function automatic v6_hdr_t aimed_header(cfg_t c);
    v6_hdr_t h;
    h.dst_high       = c.local_v6_high;
    h.dst_low        = c.local_v6_low;
    h.src_high       = c.prefix_high;
    h.src_low        = {c.prefix_mid, $urandom()};
    h.hop_count      = 8'($urandom());
    h.traffic_class  = 8'($urandom());
    h.payload_length = 16'($urandom());
    h.ext            = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 9))
      0, 1:    h.next_header = ($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_UDP;
      2:       h.next_header = 8'($urandom());
      default: h.next_header = PROTO_ICMPV6;
    endcase
    case ($urandom_range(0, 9))
      0:       h.icmp_type = ICMP6_ECHO_REQUEST;
      1:       h.icmp_type = ICMP6_ECHO_REPLY;
      2, 3:    h.icmp_type = ICMP6_DST_UNREACH;
      4:       h.icmp_type = ICMP6_PKT_TOO_BIG;
      5:       h.icmp_type = ICMP6_TIME_EXCEED;
      6, 7:    h.icmp_type = ICMP6_PARAM_PROB;
      default: h.icmp_type = 8'($urandom());
    endcase
    h.icmp_code = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 5));
    if (h.icmp_type == ICMP6_PKT_TOO_BIG) begin
      case ($urandom_range(0, 3))
        0:       h.icmp_rest = $urandom_range(0, 100);
        1:       h.icmp_rest = $urandom_range(65500, 65600);
        2:       h.icmp_rest = $urandom();
        default: h.icmp_rest = $urandom_range(1280, 9000);
      endcase
    end else if (h.icmp_type == ICMP6_PARAM_PROB && $urandom_range(0, 3) != 0) begin
      h.icmp_rest = $urandom_range(0, 45);
    end else begin
      h.icmp_rest = $urandom();
    end
    return h;
  endfunction

  function automatic v6_hdr_t noise_header();
    v6_hdr_t h;
    h.dst_high       = {$urandom(), $urandom()};
    h.dst_low        = {$urandom(), $urandom()};
    h.src_high       = {$urandom(), $urandom()};
    h.src_low        = {$urandom(), $urandom()};
    h.next_header    = 8'($urandom());
    h.hop_count      = 8'($urandom());
    h.traffic_class  = 8'($urandom());
    h.payload_length = 16'($urandom());
    h.ext            = 1'($urandom());
    h.icmp_type      = 8'($urandom());
    h.icmp_code      = 8'($urandom());
    h.icmp_rest      = $urandom();
    return h;
  endfunction

  // Queue an ICMPv6 message addressed to us.
  task automatic push_icmp(logic [7:0] ty, logic [7:0] co, logic [31:0] rest);
    v6_hdr_t h;
    h             = aimed_header(shadow_cfg);
    h.ext         = 1'b0;
    h.next_header = PROTO_ICMPV6;
    h.icmp_type   = ty;
    h.icmp_code   = co;
    h.icmp_rest   = rest;
    hdr_queue.push_back(h);
  endtask

  // ------------------------------------------------------------------------
  // Reporting
  // ------------------------------------------------------------------------

  task automatic flag_mismatch(string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                              results_seen, name, got, want));
  endtask

  // ------------------------------------------------------------------------
  // Register writes: the block is idle whenever these run
  // ------------------------------------------------------------------------

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_LOCAL_V6_HIGH: shadow_cfg.local_v6_high = data;
      REG_LOCAL_V6_LOW:  shadow_cfg.local_v6_low  = data;
      REG_PREFIX_HIGH:   shadow_cfg.prefix_high   = data;
      REG_PREFIX_MID:    shadow_cfg.prefix_mid    = data[31:0];
      REG_LOCAL_V4:      shadow_cfg.local_v4      = data[31:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Write every register, then poke an undecoded index, which must change nothing.
  task automatic program_regs(logic [63:0] v6_high, logic [63:0] v6_low,
                              logic [63:0] pfx_high, logic [63:0] pfx_mid,
                              logic [63:0] v4_addr);
    write_reg(REG_LOCAL_V6_HIGH, v6_high);
    write_reg(REG_LOCAL_V6_LOW, v6_low);
    write_reg(REG_PREFIX_HIGH, pfx_high);
    write_reg(REG_PREFIX_MID, pfx_mid);
    write_reg(REG_LOCAL_V4, v4_addr);
    write_reg(REG_UNUSED, {$urandom(), $urandom()});
    settings_used++;
  endtask

  // Wait until every queued request has gone in and every result has come out;
  // the watchdog ends the run if the block stops moving.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (hdr_queue.size() != 0 || in_valid || v4_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ------------------------------------------------------------------------
  // Request driver: offer queued headers, predict on acceptance
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    logic offer;
    offer = in_valid;
    if (!rst_n) begin
      offer = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        // the request is taken: work out what must come out for it
        v4_due.push_back(translate_header(cur_hdr, shadow_cfg));
        requests_sent++;
        offer    = 1'b0;
        send_gap = $urandom_range(0, send_gap_max);
      end
      // hold valid until accepted; only then advance to the next header
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (hdr_queue.size() != 0) begin
          cur_hdr                = hdr_queue.pop_front();
          in_dst_addr_high       <= cur_hdr.dst_high;
          in_dst_addr_low        <= cur_hdr.dst_low;
          in_src_addr_high       <= cur_hdr.src_high;
          in_src_addr_low        <= cur_hdr.src_low;
          in_next_header         <= cur_hdr.next_header;
          in_hop_count           <= cur_hdr.hop_count;
          in_traffic_class       <= cur_hdr.traffic_class;
          in_payload_length      <= cur_hdr.payload_length;
          in_ext_headers_present <= cur_hdr.ext;
          in_icmp_type_in        <= cur_hdr.icmp_type;
          in_icmp_code_in        <= cur_hdr.icmp_code;
          in_icmp_rest_in        <= cur_hdr.icmp_rest;
          offer = 1'b1;
        end
      end
    end
    in_valid <= offer;
  end

  // ------------------------------------------------------------------------
  // Result monitor: compare with the oldest prediction, pace out_ready
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    v4_hdr_t want;
    logic    rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (v4_due.size() == 0) begin
          flag_mismatch($sformatf("result with no request outstanding, verdict %0d",
                                  out_verdict));
        end else begin
          want = v4_due.pop_front();
          check_field("verdict", 64'(out_verdict), 64'(want.verdict));
          check_field("v4_source", 64'(out_v4_source), 64'(want.source));
          check_field("v4_protocol", 64'(out_v4_protocol), 64'(want.protocol));
          check_field("v4_ttl", 64'(out_v4_ttl), 64'(want.ttl));
          check_field("v4_tos", 64'(out_v4_tos), 64'(want.tos));
          check_field("v4_total_length", 64'(out_v4_total_length),
                      64'(want.total_length));
          check_field("v4_checksum", 64'(out_v4_checksum), 64'(want.checksum));
          check_field("icmp_type_out", 64'(out_icmp_type_out), 64'(want.icmp_type));
          check_field("icmp_code_out", 64'(out_icmp_code_out), 64'(want.icmp_code));
          check_field("icmp_rest_out", 64'(out_icmp_rest_out), 64'(want.icmp_rest));
          case (want.verdict)
            VERDICT_XLATE: n_xlate++;
            VERDICT_DROP:  n_drop++;
            default:       n_pass++;
          endcase
        end
        results_seen++;
        // twice in the run, hold off long enough for the block to back up
        if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND)
          hold_left = HOLD_CYCLES;
        else
          recv_gap = $urandom_range(0, recv_gap_max);
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      rdy = (hold_left == 0 && recv_gap == 0);
    end
    out_ready <= rdy;
  end

  // ------------------------------------------------------------------------
  // Watchdog: give up after a long run of cycles with no handshake at all
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus sequence
  // ------------------------------------------------------------------------
  initial begin : run_phases
    v6_hdr_t     h;
    logic [31:0] low_word;
    logic [5:0]  bit_sel;
    int          sel;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers still at reset: an aimed header has the zero IPv4
    // destination and must drop; a random one passes.
    hdr_queue.push_back(aimed_header(shadow_cfg));
    hdr_queue.push_back(noise_header());
    wait_idle();

    // Directed part under an ordinary setting.
    program_regs({$urandom(), $urandom()}, {$urandom(), 32'hC0A8_0001},
                 {$urandom(), $urandom()}, {$urandom(), $urandom()},
                 {$urandom(), 32'h0A00_0001});
    @(negedge clk);
    // wrong destination, wrong prefix word: pass untouched
    h = aimed_header(shadow_cfg);
    h.dst_high[0] = ~h.dst_high[0];
    hdr_queue.push_back(h);
    h = aimed_header(shadow_cfg);
    h.src_low[63:32] = ~h.src_low[63:32];
    hdr_queue.push_back(h);
    // extension headers: drop
    h = aimed_header(shadow_cfg);
    h.ext = 1'b1;
    hdr_queue.push_back(h);
    // plain transport headers at the field extremes; the second wraps its length
    h = aimed_header(shadow_cfg);
    h.ext = 1'b0;
    h.next_header = PROTO_TCP;
    h.hop_count = 8'h00;
    h.traffic_class = 8'h00;
    h.payload_length = 16'h0000;
    h.src_low[31:0] = 32'h0000_0000;
    hdr_queue.push_back(h);
    h.next_header = PROTO_UDP;
    h.hop_count = 8'hFF;
    h.traffic_class = 8'hFF;
    h.payload_length = 16'hFFFF;
    h.src_low[31:0] = 32'hFFFF_FFFF;
    hdr_queue.push_back(h);
    // echo, every unreachable code and one too many
    push_icmp(ICMP6_ECHO_REQUEST, CODE_ZERO, $urandom());
    push_icmp(ICMP6_ECHO_REPLY, CODE_ALL_ONES, $urandom());
    push_icmp(ICMP6_DST_UNREACH, U6_NO_ROUTE, $urandom());
    push_icmp(ICMP6_DST_UNREACH, U6_ADMIN_PROHIB, $urandom());
    push_icmp(ICMP6_DST_UNREACH, U6_BEYOND_SCOPE, $urandom());
    push_icmp(ICMP6_DST_UNREACH, U6_ADDR_UNREACH, $urandom());
    push_icmp(ICMP6_DST_UNREACH, U6_PORT_UNREACH, $urandom());
    push_icmp(ICMP6_DST_UNREACH, U6_SRC_POLICY, $urandom());
    // packet too big: normal, largest MTU, one above, wrapped below zero
    push_icmp(ICMP6_PKT_TOO_BIG, CODE_ZERO, 32'd1300);
    push_icmp(ICMP6_PKT_TOO_BIG, CODE_ZERO, 32'd65555);
    push_icmp(ICMP6_PKT_TOO_BIG, CODE_ZERO, 32'd65556);
    push_icmp(ICMP6_PKT_TOO_BIG, CODE_ZERO, 32'd10);
    push_icmp(ICMP6_TIME_EXCEED, TE6_REASSEMBLY, $urandom());
    // parameter problem: pointer remaps, an unmapped pointer, next header, bad code
    push_icmp(ICMP6_PARAM_PROB, PP6_HDR_FIELD, 32'd0);
    push_icmp(ICMP6_PARAM_PROB, PP6_HDR_FIELD, 32'd6);
    push_icmp(ICMP6_PARAM_PROB, PP6_HDR_FIELD, 32'd24);
    push_icmp(ICMP6_PARAM_PROB, PP6_HDR_FIELD, 32'd40);
    push_icmp(ICMP6_PARAM_PROB, PP6_UNREC_NH, $urandom());
    push_icmp(ICMP6_PARAM_PROB, PP6_UNREC_OPT, $urandom());
    // a type with no IPv4 counterpart
    push_icmp(ICMP6_NEIGH_SOLICIT, CODE_ZERO, $urandom());
    wait_idle();

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_regs('1, '1, '1, '1, '1);
        1: program_regs('0, '0, '0, '0, '0);
        default: begin
          // the low word of the local address doubles as the IPv4 destination
          case ($urandom_range(0, 7))
            0:       low_word = 32'h0000_0000;
            1:       low_word = {8'h7F, 24'($urandom())};
            2:       low_word = {4'hE, 28'($urandom())};
            3:       low_word = {4'hF, 28'($urandom())};
            4:       low_word = 32'hDFFF_FFFF;
            default: low_word = $urandom();
          endcase
          program_regs({$urandom(), $urandom()}, {$urandom(), low_word},
                       {$urandom(), $urandom()}, {$urandom(), $urandom()},
                       {$urandom(), $urandom()});
        end
      endcase
      // vary the pacing so that in some phases the sender, in others the receiver, runs without idling
      send_gap_max = (p % 3 == 0) ? 0 : GAP_MAX;
      recv_gap_max = (p % 4 == 1) ? 0 : GAP_MAX;
      @(negedge clk);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
          h = aimed_header(shadow_cfg);
        end else if (sel < 17) begin
          // nearly ours: spoil one address bit the match depends on
          h = aimed_header(shadow_cfg);
          bit_sel = 6'($urandom_range(0, 63));
          case ($urandom_range(0, 3))
            0: h.dst_high[bit_sel] = ~h.dst_high[bit_sel];
            1: h.dst_low[bit_sel]  = ~h.dst_low[bit_sel];
            2: h.src_high[bit_sel] = ~h.src_high[bit_sel];
            default: h.src_low[63:32] = h.src_low[63:32] ^ (32'd1 << bit_sel[4:0]);
          endcase
        end else begin
          h = noise_header();
        end
        hdr_queue.push_back(h);
      end
      wait_idle();
    end

    if (v4_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", v4_due.size()));

    $display("run: %0d requests under %0d register settings, %0d results compared",
             requests_sent, settings_used, results_seen);
    $display("run: %0d translated, %0d dropped, %0d passed, two long result stalls",
             n_xlate, n_drop, n_pass);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- ipv6_to_ipv4_header_translate.f -----
+incdir+rtl/core
rtl/core/v6v4_pkg.sv
rtl/core/v6v4_cfg.sv
rtl/core/v6v4_icmp_map.sv
rtl/core/v6v4_csum.sv
rtl/core/ipv6_to_ipv4_header_translate.sv
test/tb.sv
